// ===== hw/rtl/jzc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Joint zero calibration package
// Shared widths, codes, beat layouts and angle helpers.
// ----------------------------------------------------------------------------
package jzc_pkg;

	localparam int JOINTS     = 6;
	localparam int MAX_JOINTS = 6;
	localparam int ANG_W      = 24;
	localparam int LIM_W      = 23;
	localparam int RND_W      = 16;
	localparam int TICK_W     = 32;
	localparam int KIND_W     = 3;
	localparam int JID_W      = 3;
	localparam int STAT_W     = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int WIDE_W     = ANG_W + 2;

	localparam logic [MAX_JOINTS-1:0] ALL_MASK = MAX_JOINTS'((1 << JOINTS) - 1);

	localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(8388607);
	localparam logic signed [WIDE_W-1:0] SAT_LO = -WIDE_W'(8388608);

	typedef enum logic [KIND_W-1:0] {
		K_START_CHECK,
		K_CHECK_UPDATE,
		K_START_JOINT,
		K_CONFIRM,
		K_VERIFY,
		K_END,
		K_RAW2MODEL,
		K_MODEL2RAW
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_NONE,
		ST_SUCCESS,
		ST_REJECTED,
		ST_OUT_OF_TOL,
		ST_TIMEOUT
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOST,
		MODE_CHECKING,
		MODE_OK,
		MODE_CALIB
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIFT,
		CFG_ARRIVAL,
		CFG_ROUNDS,
		CFG_TIMEOUT,
		CFG_DIR
	} cfg_idx_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [JID_W-1:0]        joint_sel;
		logic signed [ANG_W-1:0] angle;
		logic [TICK_W-1:0]       sys_tick;
		logic signed [ANG_W-1:0] angle_joint_1;
		logic signed [ANG_W-1:0] angle_joint_2;
		logic signed [ANG_W-1:0] angle_joint_3;
		logic signed [ANG_W-1:0] angle_joint_4;
		logic signed [ANG_W-1:0] angle_joint_5;
		logic signed [ANG_W-1:0] angle_joint_6;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [ANG_W-1:0] value;
		logic [MODE_W-1:0]       mode;
		logic [MAX_JOINTS-1:0]   valid_mask;
		logic                    zero_verified;
	} result_t;

	typedef struct packed {
		logic [LIM_W-1:0]      drift_limit;
		logic [LIM_W-1:0]      arrival_limit;
		logic [RND_W-1:0]      min_rounds;
		logic [TICK_W-1:0]     timeout_ticks;
		logic [MAX_JOINTS-1:0] direction_mask;
	} cfg_t;

	function automatic logic [ANG_W-1:0] ang_mag(input logic signed [ANG_W-1:0] a);
		logic [ANG_W-1:0] u;
		u = a;
		return a[ANG_W-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic logic signed [WIDE_W-1:0] ang_wide(input logic signed [ANG_W-1:0] a);
		return $signed({{(WIDE_W - ANG_W){a[ANG_W-1]}}, a});
	endfunction

	function automatic logic signed [ANG_W-1:0] ang_sat(input logic signed [WIDE_W-1:0] v);
		logic signed [ANG_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[ANG_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[ANG_W-1:0];
		end else begin
			r = v[ANG_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/jzc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Joint zero calibration channels
// Valid/ready channels for command beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface jzc_item_if;
	import jzc_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jzc_result_if;
	import jzc_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jzc_cfg_if;
	import jzc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/jzc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Joint zero calibration registers
// Holds the tolerances, round count, deadline and direction bits.
// ----------------------------------------------------------------------------
module jzc_cfg (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jzc_cfg_if.sink    cfg,
	output jzc_pkg::cfg_t regs
);
	import jzc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.drift_limit    <= LIM_W'(128);
			regs_q.arrival_limit  <= LIM_W'(128);
			regs_q.min_rounds     <= RND_W'(10);
			regs_q.timeout_ticks  <= TICK_W'(3000);
			regs_q.direction_mask <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_DRIFT:   regs_q.drift_limit    <= cfg.data[LIM_W-1:0];
				CFG_ARRIVAL: regs_q.arrival_limit  <= cfg.data[LIM_W-1:0];
				CFG_ROUNDS:  regs_q.min_rounds     <= cfg.data[RND_W-1:0];
				CFG_TIMEOUT: regs_q.timeout_ticks  <= cfg.data[TICK_W-1:0];
				CFG_DIR:     regs_q.direction_mask <= cfg.data[MAX_JOINTS-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/jzc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Joint zero calibration core
// Calibration state, zero offsets and the combinational command decode.
// ----------------------------------------------------------------------------
module jzc_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jzc_pkg::cfg_t   regs,
	input  wire jzc_pkg::item_t  item_s1,
	input  wire logic            adv,
	output jzc_pkg::result_t     res
);
	import jzc_pkg::*;

	mode_t                   mode_q, mode_n;
	logic [MAX_JOINTS-1:0]   valid_q, valid_n;
	logic [RND_W-1:0]        round_q, round_n, round_inc;
	logic [TICK_W-1:0]       start_q, start_n, elapsed;
	logic                    verified_q, verified_n;
	logic signed [ANG_W-1:0] offsets_q [MAX_JOINTS];
	logic                    off_we;

	logic signed [ANG_W-1:0] snap [MAX_JOINTS];
	logic [MAX_JOINTS-1:0]   drift_mask;
	logic [JID_W-1:0]        jidx;
	logic                    jok;
	logic                    dir_neg;
	logic signed [ANG_W-1:0] off_sel;
	logic signed [WIDE_W-1:0] diff, neg_diff, mdl, sum;
	logic signed [ANG_W-1:0] r2m, m2r;
	logic                    judge, timed_out;
	status_t                 status;
	logic signed [ANG_W-1:0] value;

	assign jidx    = item_s1.joint_sel - 1'b1;
	assign jok     = (item_s1.joint_sel != '0) && (item_s1.joint_sel <= JID_W'(JOINTS));
	assign dir_neg = jok ? regs.direction_mask[jidx] : 1'b0;
	assign off_sel = jok ? offsets_q[jidx] : '0;

	assign diff     = ang_wide(item_s1.angle) - ang_wide(off_sel);
	assign neg_diff = -diff;
	assign r2m      = ang_sat(dir_neg ? neg_diff : diff);
	assign mdl      = dir_neg ? -ang_wide(item_s1.angle) : ang_wide(item_s1.angle);
	assign sum      = ang_wide(off_sel) + mdl;
	assign m2r      = ang_sat(sum);

	assign snap[0] = item_s1.angle_joint_1;
	assign snap[1] = item_s1.angle_joint_2;
	assign snap[2] = item_s1.angle_joint_3;
	assign snap[3] = item_s1.angle_joint_4;
	assign snap[4] = item_s1.angle_joint_5;
	assign snap[5] = item_s1.angle_joint_6;

	always_comb begin
		for (int i = 0; i < MAX_JOINTS; i++) begin
			drift_mask[i] = (i < JOINTS) &&
				(ang_mag(snap[i]) <= {1'b0, regs.drift_limit});
		end
	end

	assign round_inc = (round_q != '1) ? round_q + 1'b1 : round_q;
	assign judge     = round_inc >= regs.min_rounds;
	assign elapsed   = item_s1.sys_tick - start_q;
	assign timed_out = elapsed > regs.timeout_ticks;

	always_comb begin
		mode_n     = mode_q;
		valid_n    = valid_q;
		round_n    = round_q;
		start_n    = start_q;
		verified_n = verified_q;
		off_we     = 1'b0;
		status     = ST_NONE;
		value      = '0;
		case (kind_t'(item_s1.kind))
			K_START_CHECK: begin
				mode_n  = MODE_CHECKING;
				start_n = item_s1.sys_tick;
				round_n = '0;
				valid_n = '0;
				status  = ST_SUCCESS;
			end
			K_CHECK_UPDATE: begin
				if (mode_q == MODE_CHECKING) begin
					round_n = round_inc;
					if (judge) begin
						valid_n = drift_mask;
						if (drift_mask == ALL_MASK) begin
							mode_n = MODE_OK;
							status = ST_SUCCESS;
						end else if (timed_out) begin
							mode_n = MODE_LOST;
							status = ST_TIMEOUT;
						end
					end
				end
			end
			K_START_JOINT: begin
				if ((mode_q inside {MODE_OK, MODE_CALIB}) && jok) begin
					mode_n = MODE_CALIB;
					status = ST_SUCCESS;
				end else begin
					status = ST_REJECTED;
				end
			end
			K_CONFIRM: begin
				if (mode_q == MODE_CALIB && jok) begin
					// Reading the raw angle back through the offset just captured
					// gives a model angle of zero, which is always within tolerance.
					off_we        = 1'b1;
					verified_n    = 1'b1;
					valid_n[jidx] = 1'b1;
					status        = ST_SUCCESS;
				end else begin
					status = ST_REJECTED;
				end
			end
			K_VERIFY: begin
				if (!jok) begin
					status = ST_REJECTED;
				end else if (ang_mag(item_s1.angle) <= {1'b0, regs.arrival_limit}) begin
					valid_n[jidx] = 1'b1;
					status        = ST_SUCCESS;
				end else begin
					status = ST_OUT_OF_TOL;
				end
			end
			K_END: begin
				mode_n = ((valid_q & ALL_MASK) == ALL_MASK) ? MODE_OK : MODE_LOST;
				status = ST_SUCCESS;
			end
			K_RAW2MODEL: begin
				value  = jok ? r2m : item_s1.angle;
				status = ST_SUCCESS;
			end
			K_MODEL2RAW: begin
				value  = jok ? m2r : item_s1.angle;
				status = ST_SUCCESS;
			end
			default: ;
		endcase
	end

	assign res.status        = status;
	assign res.value         = value;
	assign res.mode          = mode_n;
	assign res.valid_mask    = valid_n;
	assign res.zero_verified = verified_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LOST;
			valid_q    <= '0;
			round_q    <= '0;
			start_q    <= '0;
			verified_q <= 1'b0;
			for (int i = 0; i < MAX_JOINTS; i++) begin
				offsets_q[i] <= '0;
			end
		end else if (adv) begin
			mode_q     <= mode_n;
			valid_q    <= valid_n;
			round_q    <= round_n;
			start_q    <= start_n;
			verified_q <= verified_n;
			if (off_we) begin
				offsets_q[jidx] <= item_s1.angle;
			end
		end
	end

`ifndef SYNTHESIS
	a_timeout_lost: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.status == ST_TIMEOUT |-> res.mode == MODE_LOST)
		else $error("timeout beat without lost mode");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.status == ST_REJECTED |=>
			mode_q == $past(mode_q) && valid_q == $past(valid_q))
		else $error("rejected command changed calibration state");

	a_calib_entry: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.mode == MODE_CALIB |-> mode_q == MODE_OK || mode_q == MODE_CALIB)
		else $error("calibrating entered from lost or checking");

	a_upper_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & ~ALL_MASK) == '0)
		else $error("valid bit set for a joint that does not exist");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/joint_zero_calibration_fsm_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Joint zero calibration controller
// Power-up zero check, single-joint zero capture, verify and angle conversion.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat. A command is registered
// on acceptance and decoded against the calibration state when the output
// register is free or being read; the result is then loaded into it and the
// state is updated, both in the same cycle.
// One command is accepted every cycle while results are taken; the rate is
// set by the loop through the calibration state registers.
// Register writes take effect on the beat after the write.
// ----------------------------------------------------------------------------
module joint_zero_calibration_fsm_top (
	input  wire logic clk,
	input  wire logic arst_n,
	jzc_item_if.sink     item,
	jzc_result_if.source result,
	jzc_cfg_if.sink      cfg
);
	import jzc_pkg::*;

	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	jzc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	jzc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.item_s1 (item_s1),
		.adv     (adv),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ===== dv/joint_zero_calibration_fsm_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joint zero calibration controller test
// Drives command beats into the controller and compares every result beat
// field by field against a cycle-free model of the calibration state kept in
// this bench. Directed checks cover the power-up check, its deadline with tick
// wrap, joint capture, verify, end, saturating conversions and the round
// threshold. Randomized calibration sessions follow under several register
// settings, with random gaps on both the command and result sides but in one calm phase.
// ----------------------------------------------------------------------------
module joint_zero_calibration_fsm_top_test;
	import jzc_pkg::*;

	localparam int LIM_MAX = 8388607;
	localparam logic signed [ANG_W-1:0] ANG_TOP    = 24'sh7FFFFF;
	localparam logic signed [ANG_W-1:0] ANG_BOTTOM = 24'sh800000;

	logic clk = 1'b0;
	logic arst_n;

	jzc_item_if   cmd_ch();
	jzc_result_if res_ch();
	jzc_cfg_if    cfg_ch();

	joint_zero_calibration_fsm_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	logic [LIM_W-1:0]      lim_drift    = 23'd128;
	logic [LIM_W-1:0]      lim_arrival  = 23'd128;
	logic [RND_W-1:0]      need_rounds  = 16'd10;
	logic [TICK_W-1:0]     tick_budget  = 32'd3000;
	logic [MAX_JOINTS-1:0] dir_neg_mask = '0;

	mode_t                   p_mode     = MODE_LOST;
	logic signed [ANG_W-1:0] p_offset [MAX_JOINTS];
	logic [MAX_JOINTS-1:0]   p_valid    = '0;
	logic [RND_W-1:0]        p_rounds   = '0;
	logic [TICK_W-1:0]       p_start    = '0;
	logic [JID_W-1:0]        p_active   = '0;
	logic                    p_verified = 1'b0;

	result_t         report_fifo [$];
	logic [TICK_W-1:0] tick_now   = '0;
	bit              calm       = 1'b0;
	int              mismatches = 0;
	int              sent_cmds  = 0;
	int              seen_reports = 0;
	int              reg_writes = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("joint_zero_calibration_fsm_top_test: FAIL");
		$finish;
	end

	function automatic longint angle_abs(input logic signed [ANG_W-1:0] a);
		longint w;
		w = a;
		return (w < 0) ? -w : w;
	endfunction

	function automatic logic signed [ANG_W-1:0] clamp_angle(input longint v);
		if (v > longint'(LIM_MAX)) begin
			return ANG_TOP;
		end
		if (v < -longint'(LIM_MAX) - 1) begin
			return ANG_BOTTOM;
		end
		return v[ANG_W-1:0];
	endfunction

	function automatic logic signed [ANG_W-1:0] raw_to_model(input int idx,
			input logic signed [ANG_W-1:0] raw);
		longint d;
		d = longint'(raw) - longint'(p_offset[idx]);
		if (dir_neg_mask[idx]) begin
			d = -d;
		end
		return clamp_angle(d);
	endfunction

	function automatic logic signed [ANG_W-1:0] model_to_raw(input int idx,
			input logic signed [ANG_W-1:0] model);
		longint m;
		m = model;
		if (dir_neg_mask[idx]) begin
			m = -m;
		end
		return clamp_angle(longint'(p_offset[idx]) + m);
	endfunction

	// Applies one command to the calibration state and returns its report.
	function automatic result_t next_report(input item_t it);
		result_t                 r;
		logic [MAX_JOINTS-1:0]   hit;
		logic [TICK_W-1:0]       elapsed;
		logic signed [ANG_W-1:0] snap [MAX_JOINTS];
		bit                      jid_ok;
		int                      idx;
		r = '0;
		r.status = ST_NONE;
		jid_ok = (it.joint_sel >= 3'd1) && (it.joint_sel <= JID_W'(JOINTS));
		idx = int'(it.joint_sel) - 1;
		snap = '{it.angle_joint_1, it.angle_joint_2, it.angle_joint_3,
			it.angle_joint_4, it.angle_joint_5, it.angle_joint_6};
		case (kind_t'(it.kind))
			K_START_CHECK: begin
				p_mode = MODE_CHECKING;
				p_start = it.sys_tick;
				p_rounds = '0;
				p_valid = '0;
				r.status = ST_SUCCESS;
			end
			K_CHECK_UPDATE: begin
				if (p_mode == MODE_CHECKING) begin
					if (p_rounds != 16'hFFFF) begin
						p_rounds = p_rounds + 1'b1;
					end
					if (p_rounds >= need_rounds) begin
						hit = '0;
						for (int j = 0; j < JOINTS; j++) begin
							if (angle_abs(snap[j]) <= longint'(lim_drift)) begin
								hit[j] = 1'b1;
							end
						end
						p_valid = hit;
						elapsed = it.sys_tick - p_start;
						if (hit == ALL_MASK) begin
							p_mode = MODE_OK;
							r.status = ST_SUCCESS;
						end else if (elapsed > tick_budget) begin
							p_mode = MODE_LOST;
							r.status = ST_TIMEOUT;
						end
					end
				end
			end
			K_START_JOINT: begin
				if ((p_mode != MODE_OK && p_mode != MODE_CALIB) || !jid_ok) begin
					r.status = ST_REJECTED;
				end else begin
					p_mode = MODE_CALIB;
					p_active = it.joint_sel;
					r.status = ST_SUCCESS;
				end
			end
			K_CONFIRM: begin
				if (p_mode != MODE_CALIB || !jid_ok) begin
					r.status = ST_REJECTED;
				end else begin
					p_offset[idx] = it.angle;
					p_verified = 1'b0;
					if (angle_abs(raw_to_model(idx, it.angle)) <= longint'(lim_drift)) begin
						p_verified = 1'b1;
						p_valid[idx] = 1'b1;
						r.status = ST_SUCCESS;
					end else begin
						p_valid[idx] = 1'b0;
						r.status = ST_OUT_OF_TOL;
					end
				end
			end
			K_VERIFY: begin
				if (!jid_ok) begin
					r.status = ST_REJECTED;
				end else if (angle_abs(it.angle) <= longint'(lim_arrival)) begin
					p_valid[idx] = 1'b1;
					r.status = ST_SUCCESS;
				end else begin
					r.status = ST_OUT_OF_TOL;
				end
			end
			K_END: begin
				p_mode = ((p_valid & ALL_MASK) == ALL_MASK) ? MODE_OK : MODE_LOST;
				p_active = '0;
				r.status = ST_SUCCESS;
			end
			K_RAW2MODEL: begin
				r.value = jid_ok ? raw_to_model(idx, it.angle) : it.angle;
				r.status = ST_SUCCESS;
			end
			default: begin
				r.value = jid_ok ? model_to_raw(idx, it.angle) : it.angle;
				r.status = ST_SUCCESS;
			end
		endcase
		r.mode = p_mode;
		r.valid_mask = p_valid;
		r.zero_verified = p_verified;
		return r;
	endfunction

	function automatic logic [TICK_W-1:0] next_tick();
		if ($urandom_range(0, 99) < 10) begin
			tick_now = tick_now + $urandom;
		end else begin
			tick_now = tick_now + $urandom_range(0, 40);
		end
		return tick_now;
	endfunction

	function automatic logic signed [ANG_W-1:0] rand_angle(input int lim);
		int p;
		int v;
		p = $urandom_range(0, 99);
		if (p < 45) begin
			v = int'($urandom_range(0, 2 * lim)) - lim;
		end else if (p < 60) begin
			v = lim + int'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				v = -v;
			end
		end else if (p < 70) begin
			v = $urandom_range(0, 1) ? LIM_MAX : -LIM_MAX - 1;
		end else begin
			v = $urandom;
		end
		return v[ANG_W-1:0];
	endfunction

	function automatic logic signed [ANG_W-1:0] snapshot_angle(input bit all_good);
		int v;
		if (all_good || $urandom_range(0, 99) < 70) begin
			v = int'($urandom_range(0, 2 * int'(lim_drift))) - int'(lim_drift);
			return v[ANG_W-1:0];
		end
		return rand_angle(int'(lim_drift));
	endfunction

	function automatic logic [JID_W-1:0] rand_jid();
		if ($urandom_range(0, 99) < 85) begin
			return JID_W'($urandom_range(1, JOINTS));
		end
		return $urandom_range(0, 1) ? 3'd0 : 3'd7;
	endfunction

	function automatic item_t base_cmd(input kind_t k);
		item_t it;
		it.kind = k;
		it.joint_sel = JID_W'($urandom);
		it.angle = ANG_W'($urandom);
		it.sys_tick = next_tick();
		it.angle_joint_1 = ANG_W'($urandom);
		it.angle_joint_2 = ANG_W'($urandom);
		it.angle_joint_3 = ANG_W'($urandom);
		it.angle_joint_4 = ANG_W'($urandom);
		it.angle_joint_5 = ANG_W'($urandom);
		it.angle_joint_6 = ANG_W'($urandom);
		return it;
	endfunction

	function automatic item_t directed_cmd(input kind_t k, input logic [JID_W-1:0] jid,
			input logic signed [ANG_W-1:0] ang, input logic [TICK_W-1:0] tick);
		item_t it;
		it = '0;
		it.kind = k;
		it.joint_sel = jid;
		it.angle = ang;
		it.sys_tick = tick;
		return it;
	endfunction

	function automatic item_t update_cmd(input logic [TICK_W-1:0] tick,
			input logic signed [ANG_W-1:0] good, input logic signed [ANG_W-1:0] bad,
			input logic [MAX_JOINTS-1:0] bad_mask);
		item_t it;
		it = directed_cmd(K_CHECK_UPDATE, 3'd0, 24'sd0, tick);
		it.angle_joint_1 = bad_mask[0] ? bad : good;
		it.angle_joint_2 = bad_mask[1] ? bad : good;
		it.angle_joint_3 = bad_mask[2] ? bad : good;
		it.angle_joint_4 = bad_mask[3] ? bad : good;
		it.angle_joint_5 = bad_mask[4] ? bad : good;
		it.angle_joint_6 = bad_mask[5] ? bad : good;
		return it;
	endfunction

	task automatic send_cmd(input item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 7) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= it;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		report_fifo.push_back(next_report(it));
		sent_cmds++;
	endtask

	// Every command yields one report, so an empty queue plus the pipeline
	// depth means the controller is idle.
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (report_fifo.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_DRIFT:   lim_drift    = val[LIM_W-1:0];
			CFG_ARRIVAL: lim_arrival  = val[LIM_W-1:0];
			CFG_ROUNDS:  need_rounds  = val[RND_W-1:0];
			CFG_TIMEOUT: tick_budget  = val;
			CFG_DIR:     dir_neg_mask = val[MAX_JOINTS-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 100) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		end
	endtask

	initial begin : report_check
		result_t got;
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (report_fifo.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with no command outstanding, actual status %0d",
						$time, got.status);
				end else begin
					want = report_fifo.pop_front();
					seen_reports++;
					check_field("status", want.status, got.status);
					check_field("value", $signed(want.value), $signed(got.value));
					check_field("mode", want.mode, got.mode);
					check_field("valid_mask", want.valid_mask, got.valid_mask);
					check_field("zero_verified", want.zero_verified, got.zero_verified);
				end
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	task automatic test_power_up_check();
		write_reg(CFG_ROUNDS, 32'd2);
		send_cmd(update_cmd(32'd10, 24'sd0, 24'sd0, 6'h00));
		send_cmd(directed_cmd(K_START_CHECK, 3'd0, 24'sd0, 32'd1000));
		send_cmd(update_cmd(32'd1001, 24'sd0, ANG_BOTTOM, 6'h3F));
		send_cmd(update_cmd(32'd1002, 24'sd127, ANG_TOP, 6'h04));
		send_cmd(update_cmd(32'd1003, -24'sd128, 24'sd0, 6'h00));
	endtask

	// The deadline is measured across the tick wrap; 3000 ticks is still in time.
	task automatic test_check_timeout();
		send_cmd(directed_cmd(K_START_CHECK, 3'd0, 24'sd0, 32'hFFFFFF00));
		send_cmd(update_cmd(32'hFFFFFF10, 24'sd0, 24'sd129, 6'h20));
		send_cmd(update_cmd(32'h00000AB8, 24'sd0, 24'sd129, 6'h20));
		send_cmd(update_cmd(32'h00000AB9, 24'sd0, 24'sd129, 6'h20));
	endtask

	task automatic test_joint_calibration();
		send_cmd(directed_cmd(K_START_JOINT, 3'd3, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_CONFIRM, 3'd3, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_VERIFY, 3'd0, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_VERIFY, 3'd6, 24'sd129, 32'd0));
		send_cmd(directed_cmd(K_END, 3'd0, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_VERIFY, 3'd6, -24'sd128, 32'd0));
		send_cmd(directed_cmd(K_END, 3'd0, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_CONFIRM, 3'd2, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_START_JOINT, 3'd0, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_START_JOINT, 3'd7, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_START_JOINT, 3'd2, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_CONFIRM, 3'd7, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_CONFIRM, 3'd5, ANG_TOP, 32'd0));
		send_cmd(directed_cmd(K_START_JOINT, 3'd1, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_CONFIRM, 3'd1, ANG_BOTTOM, 32'd0));
	endtask

	task automatic test_conversion_saturation();
		write_reg(CFG_DIR, 32'h10);
		write_reg(CFG_ARRIVAL, 32'd0);
		send_cmd(directed_cmd(K_RAW2MODEL, 3'd5, ANG_BOTTOM, 32'd0));
		send_cmd(directed_cmd(K_MODEL2RAW, 3'd5, ANG_BOTTOM, 32'd0));
		send_cmd(directed_cmd(K_MODEL2RAW, 3'd1, ANG_BOTTOM, 32'd0));
		send_cmd(directed_cmd(K_RAW2MODEL, 3'd0, 24'sd1234, 32'd0));
		send_cmd(directed_cmd(K_MODEL2RAW, 3'd7, -24'sd77, 32'd0));
		send_cmd(directed_cmd(K_VERIFY, 3'd4, 24'sd0, 32'd0));
		send_cmd(directed_cmd(K_VERIFY, 3'd4, -24'sd1, 32'd0));
		send_cmd(directed_cmd(K_END, 3'd0, 24'sd0, 32'd0));
	endtask

	// Below the round threshold updates are counted but never judged, even
	// with the deadline long past.
	task automatic test_round_threshold();
		write_reg(CFG_DRIFT, 32'd1);
		write_reg(CFG_ROUNDS, 32'd65535);
		send_cmd(directed_cmd(K_START_CHECK, 3'd0, 24'sd0, 32'd0));
		repeat (6) send_cmd(update_cmd(32'hFFFFFFFF, 24'sd0, 24'sd2, 6'h01));
		write_reg(CFG_ROUNDS, 32'd4);
		send_cmd(update_cmd(32'd0, 24'sd0, -24'sd2, 6'h02));
		send_cmd(update_cmd(32'd0, 24'sd1, 24'sd0, 6'h00));
	endtask

	task automatic run_session();
		item_t it;
		int    rounds;
		int    ops;
		int    pick;
		bit    all_good;
		send_cmd(base_cmd(K_START_CHECK));
		rounds = int'(need_rounds) + $urandom_range(0, 4);
		for (int r = 0; r < rounds && p_mode == MODE_CHECKING; r++) begin
			it = base_cmd(K_CHECK_UPDATE);
			all_good = ($urandom_range(0, 99) < 60);
			it.angle_joint_1 = snapshot_angle(all_good);
			it.angle_joint_2 = snapshot_angle(all_good);
			it.angle_joint_3 = snapshot_angle(all_good);
			it.angle_joint_4 = snapshot_angle(all_good);
			it.angle_joint_5 = snapshot_angle(all_good);
			it.angle_joint_6 = snapshot_angle(all_good);
			send_cmd(it);
		end
		if (p_mode == MODE_LOST && $urandom_range(0, 1)) begin
			for (int j = 1; j <= JOINTS; j++) begin
				it = base_cmd(K_VERIFY);
				it.joint_sel = JID_W'(j);
				it.angle = ANG_W'(int'($urandom_range(0, 2 * int'(lim_arrival)))
					- int'(lim_arrival));
				send_cmd(it);
			end
			send_cmd(base_cmd(K_END));
		end
		ops = $urandom_range(4, 14);
		repeat (ops) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				it = base_cmd(K_START_JOINT);
				it.joint_sel = rand_jid();
			end else if (pick < 40) begin
				it = base_cmd(K_CONFIRM);
				it.joint_sel = (p_active != 0 && $urandom_range(0, 99) < 60) ? p_active
					: rand_jid();
				it.angle = rand_angle(int'(lim_drift));
			end else if (pick < 52) begin
				it = base_cmd(K_VERIFY);
				it.joint_sel = rand_jid();
				it.angle = rand_angle(int'(lim_arrival));
			end else if (pick < 80) begin
				it = base_cmd($urandom_range(0, 1) ? K_RAW2MODEL : K_MODEL2RAW);
				it.joint_sel = rand_jid();
				it.angle = rand_angle(int'(lim_drift));
			end else if (pick < 87) begin
				it = base_cmd(K_END);
			end else begin
				it = base_cmd(kind_t'($urandom_range(0, 7)));
			end
			send_cmd(it);
		end
	endtask

	task automatic test_random_phases();
		int               goal;
		logic [31:0]      d;
		logic [31:0]      a;
		logic [31:0]      r;
		logic [31:0]      t;
		logic [31:0]      m;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					d = 1; a = 0; r = 0; t = 0; m = 0;
				end
				1: begin
					d = LIM_MAX; a = LIM_MAX; r = 3; t = 32'hFFFFFFFF; m = 32'h3F;
				end
				default: begin
					d = $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(1, LIM_MAX);
					a = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, LIM_MAX);
					r = $urandom_range(0, 6);
					t = $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom;
					m = $urandom_range(0, 63);
				end
			endcase
			write_reg(CFG_DRIFT, d);
			write_reg(CFG_ARRIVAL, a);
			write_reg(CFG_ROUNDS, r);
			write_reg(CFG_TIMEOUT, t);
			write_reg(CFG_DIR, m);
			calm = (phase == 2);
			goal = sent_cmds + 425;
			while (sent_cmds < goal) run_session();
			calm = 1'b0;
		end
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (int j = 0; j < MAX_JOINTS; j++) begin
			p_offset[j] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_up_check();
		test_check_timeout();
		test_joint_calibration();
		test_conversion_saturation();
		test_round_threshold();
		test_random_phases();

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		guard = 0;
		while (report_fifo.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		if (report_fifo.size() != 0) begin
			mismatches++;
			$display("%0t: %0d result beats never arrived", $time, report_fifo.size());
		end
		repeat (10) @(posedge clk);
		$display("Sent %0d command beats and checked %0d result beats over %0d register writes,",
			sent_cmds, seen_reports, reg_writes);
		$display("including the round threshold and saturating conversions; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("joint_zero_calibration_fsm_top_test: PASS");
		end else begin
			$display("joint_zero_calibration_fsm_top_test: FAIL");
		end
		$finish;
	end

endmodule
